// File: rtl/core/stable_priority_queue_defines.svh
// Assertion macros shared by the queue RTL.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message string.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/spq_pkg.sv
package spq_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned ID_W      = 16;
    localparam int unsigned PRIO_W    = 3;
    localparam int unsigned MEM_W     = 16;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned STAT_W    = 2;
    localparam int unsigned OCC_W     = 5;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [MEM_W-1:0]  mem;
    } t_entry;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

// File: rtl/core/stable_priority_queue.sv
// Sequence: a rejected insert or remove and a no-op go straight to the result state, a
// remove first takes the head in S_REM, and an insert or a search walks the entry store
// one entry per cycle through its single read port before the result strobe.
// Throughput: one item at a time; the next item is taken in the cycle the strobe shows.
// Reset is synchronous and active low; it empties the queue without touching the store.
// Results are not held: the receiver cannot stall and must take the strobed cycle.
`include "stable_priority_queue_defines.svh"

module stable_priority_queue import spq_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [ID_W-1:0]   i_proc_id,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic [MEM_W-1:0]  i_mem_mb,
    output logic              o_done,
    output logic [STAT_W-1:0] o_status,
    output logic              o_found,
    output logic [ID_W-1:0]   o_head_id,
    output logic [PRIO_W-1:0] o_head_priority,
    output logic [MEM_W-1:0]  o_head_mem_mb,
    output logic [OCC_W-1:0]  o_occupancy
);

    // The queue is a ring in the entry store. r_head is the physical slot of the
    // most urgent entry and r_count the number of valid entries from it on.
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = AW + 1;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_INS     = 6'b000010,
        S_INS_FIN = 6'b000100,
        S_SRCH    = 6'b001000,
        S_REM     = 6'b010000,
        S_RES     = 6'b100000
    } t_state;

    function automatic logic [AW-1:0] f_succ(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_pred(input logic [AW-1:0] a);
        return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
    endfunction

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head,  n_head;
    logic [AW-1:0] r_raddr, n_raddr;
    logic [AW-1:0] r_qaddr, n_qaddr;
    logic [CW-1:0] r_left,  n_left;
    logic          r_pend,  n_pend;
    t_entry        r_new,   n_new;
    logic          r_done,  n_done;
    t_status       r_status, n_status;
    logic          r_found, n_found;
    t_entry        r_out,   n_out;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic          issue;
    logic [SW-1:0] s_sum;
    logic [SW-1:0] s_wrap;

    spq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Physical slot just past the tail; the tail itself is its predecessor.
    always_comb begin
        s_sum  = {1'b0, r_head} + SW'(r_count);
        s_wrap = (s_sum >= SW'(DEPTH)) ? s_sum - SW'(DEPTH) : s_sum;
    end

    // Insert walks from the tail toward the head. Each cycle it reads the next
    // entry while it judges the one read the cycle before: an entry that is
    // strictly less urgent moves one slot toward the tail, and the first entry
    // that is as urgent or more stops the walk, so the new entry lands behind
    // it and equal priorities stay first in, first out. During the walk a write goes
    // one slot above the entry just judged, never to a slot still to be read.
    // Search walks from the head toward the tail in the same way.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_head    = r_head;
        n_raddr   = r_raddr;
        n_qaddr   = r_qaddr;
        n_left    = r_left;
        n_pend    = r_pend;
        n_new     = r_new;
        n_done    = 1'b0;
        n_status  = r_status;
        n_found   = r_found;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_qaddr;
        mem_wdata = r_new;
        mem_raddr = r_raddr;
        issue     = 1'b0;

        case (r_state)
            S_IDLE: begin
                // The head is read on every idle cycle so a remove has it at once.
                mem_raddr = r_head;
                if (start) begin
                    n_pend     = 1'b0;
                    n_new.id   = i_proc_id;
                    n_new.prio = i_priority_req;
                    n_new.mem  = i_mem_mb;
                    n_status   = ST_DONE;
                    n_found    = 1'b0;
                    n_out      = '0;
                    case (t_cmd'(i_command))
                        CMD_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_RES;
                            end else begin
                                n_raddr = f_pred(AW'(s_wrap));
                                n_left  = r_count;
                                n_state = S_INS;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RES;
                            end else begin
                                n_state = S_REM;
                            end
                        end
                        CMD_SEARCH: begin
                            n_raddr = r_head;
                            n_left  = r_count;
                            n_state = S_SRCH;
                        end
                        default: begin
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_INS: begin
                issue  = (r_left > CW'(r_pend));
                n_pend = issue;
                if (issue) begin
                    n_raddr = f_pred(r_raddr);
                    n_qaddr = r_raddr;
                end
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = f_succ(r_qaddr);
                    if (mem_rdata.prio > r_new.prio) begin
                        mem_wdata = mem_rdata;
                        n_left    = r_left - CW'(1);
                        if (r_left == CW'(1)) begin
                            n_state = S_INS_FIN;
                        end
                    end else begin
                        mem_wdata = r_new;
                        n_count   = r_count + CW'(1);
                        n_state   = S_RES;
                    end
                end else if (r_left == '0) begin
                    // Empty queue: the tail's successor is the head slot.
                    mem_we    = 1'b1;
                    mem_waddr = f_succ(r_raddr);
                    mem_wdata = r_new;
                    n_count   = r_count + CW'(1);
                    n_state   = S_RES;
                end
            end
            S_INS_FIN: begin
                // Every entry was less urgent; the new one takes the head slot.
                mem_we    = 1'b1;
                mem_waddr = r_qaddr;
                mem_wdata = r_new;
                n_count   = r_count + CW'(1);
                n_state   = S_RES;
            end
            S_SRCH: begin
                issue  = (r_left > CW'(r_pend));
                n_pend = issue;
                if (issue) begin
                    n_raddr = f_succ(r_raddr);
                    n_qaddr = r_raddr;
                end
                if (r_pend) begin
                    if (mem_rdata.id == r_new.id) begin
                        n_found = 1'b1;
                        n_state = S_RES;
                    end else begin
                        n_left = r_left - CW'(1);
                        if (r_left == CW'(1)) begin
                            n_state = S_RES;
                        end
                    end
                end else if (r_left == '0) begin
                    n_state = S_RES;
                end
            end
            S_REM: begin
                n_out   = mem_rdata;
                n_head  = f_succ(r_head);
                n_count = r_count - CW'(1);
                n_state = S_RES;
            end
            S_RES: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_left  <= n_left;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_raddr  <= n_raddr;
        r_qaddr  <= n_qaddr;
        r_new    <= n_new;
        r_status <= n_status;
        r_found  <= n_found;
        r_out    <= n_out;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_found         = r_found;
    assign o_head_id       = r_out.id;
    assign o_head_priority = r_out.prio;
    assign o_head_mem_mb   = r_out.mem;
    assign o_occupancy     = OCC_W'(r_count);

    `SPQ_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result strobe while busy")
    `SPQ_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done, "accept not followed by busy")
    `SPQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "entry count above depth")
    `SPQ_ASSERT_IMP(a_walk_pend, i_clk, i_rst_n, r_pend, r_left != '0, "read in flight with nothing left")

endmodule

// File: rtl/core/spq_ram.sv
// Entry store: one write port, one read port, registered read data.
module spq_ram import spq_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
